// ===== rtl/ppbd_pkg.sv =====
package ppbd_pkg;

  // Width of the first_pixel result field
  localparam int unsigned PIXEL_FIELD_W = 24;
  localparam int unsigned CFG_DATA_W    = 24;

  // Depth of the run queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [7:0] NOOP_HEADER = 8'd128;
  localparam logic [7:0] BYTE_MASK   = 8'hFF;
  localparam logic [2:0] MAX_PLANES  = 3'd4;

  // Packet parser states
  localparam logic [1:0] MODE_HEADER  = 2'd0;
  localparam logic [1:0] MODE_LITERAL = 2'd1;
  localparam logic [1:0] MODE_REPEAT  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_PIXELS_PER_PLANE = 2'd0;
  localparam logic [1:0] CFG_PLANES_CODED     = 2'd1;
  localparam logic [1:0] CFG_COMPRESSED_MODE  = 2'd2;

  typedef struct packed {
    logic [1:0] plane;
    logic [7:0] count;
    logic [7:0] value;
    logic       last_plane;
  } ppbd_run_t;

endpackage

// ===== rtl/ppbd_front.sv =====
module ppbd_front import ppbd_pkg::*; #(
  parameter int unsigned PIXEL_INDEX_WIDTH = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         start_of_image_i,
  input  logic [CFG_DATA_W-1:0]        pixels_per_plane_i,
  input  logic [2:0]                   planes_coded_i,
  input  logic                         compressed_mode_i,
  output logic                         push_o,
  output logic [PIXEL_INDEX_WIDTH-1:0] pos_o,
  output ppbd_run_t                    run_o
);

  localparam int unsigned PixW = PIXEL_INDEX_WIDTH;

  logic [1:0]      mode_q, mode_d, mode_s;
  logic [7:0]      lit_q, lit_d, lit_s, lit_dec;
  logic [7:0]      rep_q, rep_d, rep_s;
  logic [2:0]      plane_q, plane_d, plane_s;
  logic [PixW-1:0] pos_q, pos_d, pos_s;

  logic [2:0]      limit;
  logic            active;
  logic [PixW-1:0] size;
  logic            in_plane;
  logic [PixW-1:0] left;
  logic [7:0]      rep_clip;
  logic            emit;
  logic [7:0]      count;
  logic            packet_end;
  logic [PixW-1:0] pos_adv;
  logic [PixW-1:0] pos_next;

  // Start of image clears packet, plane and pixel state before the byte
  always_comb begin
    if (start_of_image_i) begin
      mode_s  = MODE_HEADER;
      lit_s   = '0;
      rep_s   = '0;
      plane_s = '0;
      pos_s   = '0;
    end else begin
      mode_s  = mode_q;
      lit_s   = lit_q;
      rep_s   = rep_q;
      plane_s = plane_q;
      pos_s   = pos_q;
    end
  end

  assign limit    = (planes_coded_i > MAX_PLANES) ? MAX_PLANES : planes_coded_i;
  assign active   = plane_s < limit;
  assign size     = PixW'(pixels_per_plane_i);
  assign in_plane = pos_s < size;
  assign left     = in_plane ? (size - pos_s) : '0;
  assign rep_clip = (left < PixW'(rep_s)) ? left[7:0] : rep_s;
  assign lit_dec  = lit_s - 8'd1;
  assign pos_adv  = pos_s + PixW'(count);
  assign pos_next = emit ? pos_adv : pos_s;

  // Classify the byte and pick the run it makes, if any
  always_comb begin
    emit       = 1'b0;
    count      = 8'd1;
    packet_end = 1'b0;
    mode_d     = mode_s;
    lit_d      = lit_s;
    rep_d      = rep_s;
    if (!compressed_mode_i) begin
      mode_d     = MODE_HEADER;
      lit_d      = '0;
      rep_d      = '0;
      emit       = in_plane;
      packet_end = 1'b1;
    end else begin
      unique case (mode_s)
        MODE_LITERAL: begin
          emit  = in_plane;
          lit_d = lit_dec;
          if (lit_dec == 8'd0) begin
            mode_d     = MODE_HEADER;
            packet_end = 1'b1;
          end
        end
        MODE_REPEAT: begin
          count      = rep_clip;
          emit       = rep_clip != 8'd0;
          rep_d      = '0;
          mode_d     = MODE_HEADER;
          packet_end = 1'b1;
        end
        default: begin
          if (data_byte_i < NOOP_HEADER) begin
            lit_d  = data_byte_i + 8'd1;
            mode_d = MODE_LITERAL;
          end else if (data_byte_i > NOOP_HEADER) begin
            rep_d  = (data_byte_i ^ BYTE_MASK) + 8'd2;
            mode_d = MODE_REPEAT;
          end
        end
      endcase
    end
  end

  // Commit state on an accepted beat; an idle image holds all but the clear
  logic [1:0]      mode_n;
  logic [7:0]      lit_n, rep_n;
  logic [2:0]      plane_n;
  logic [PixW-1:0] pos_n;

  always_comb begin
    mode_n  = mode_q;
    lit_n   = lit_q;
    rep_n   = rep_q;
    plane_n = plane_q;
    pos_n   = pos_q;
    if (accept_i) begin
      mode_n  = mode_s;
      lit_n   = lit_s;
      rep_n   = rep_s;
      plane_n = plane_s;
      pos_n   = pos_s;
      if (active) begin
        mode_n = mode_d;
        lit_n  = lit_d;
        rep_n  = rep_d;
        pos_n  = pos_next;
        if (packet_end && (pos_next >= size)) begin
          plane_n = plane_s + 3'd1;
          pos_n   = '0;
          mode_n  = MODE_HEADER;
          lit_n   = '0;
          rep_n   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_HEADER;
      lit_q   <= '0;
      rep_q   <= '0;
      plane_q <= '0;
      pos_q   <= '0;
    end else begin
      mode_q  <= mode_n;
      lit_q   <= lit_n;
      rep_q   <= rep_n;
      plane_q <= plane_n;
      pos_q   <= pos_n;
    end
  end

  assign push_o           = accept_i && active && emit;
  assign pos_o            = pos_s;
  assign run_o.plane      = plane_s[1:0];
  assign run_o.count      = count;
  assign run_o.value      = data_byte_i;
  assign run_o.last_plane = (plane_s + 3'd1) == limit;

  assert property (@(posedge clk_i) disable iff (!rst_ni) plane_q <= MAX_PLANES)
    else $error("plane counter ran past the last plane");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (mode_q == MODE_LITERAL) |-> (lit_q != 8'd0))
    else $error("literal packet with no bytes left");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   mode_q == MODE_HEADER || mode_q == MODE_LITERAL || mode_q == MODE_REPEAT)
    else $error("parser state code unused");

endmodule

// ===== rtl/ppbd_fifo.sv =====
module ppbd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned AddrW = $clog2(Depth);

  logic [Width-1:0] mem [Depth];
  logic [AddrW-1:0] wr_q, rd_q;
  logic [AddrW:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + AddrW'(1);
      if (pop_i)  rd_q <= rd_q + AddrW'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (AddrW + 1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (AddrW + 1)'(1);
      end
    end
  end

  assign data_o  = mem[rd_q];
  assign empty_o = cnt_q == '0;
  assign full_o  = cnt_q == (AddrW + 1)'(Depth);

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("push into full run queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("pop from empty run queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= (AddrW + 1)'(Depth))
    else $error("run queue count out of range");

endmodule

// ===== rtl/ppbd_back.sv =====
module ppbd_back import ppbd_pkg::*; #(
  parameter int unsigned PIXEL_INDEX_WIDTH = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         head_valid_i,
  input  logic [PIXEL_INDEX_WIDTH-1:0] head_pos_i,
  input  ppbd_run_t                    head_run_i,
  input  logic [CFG_DATA_W-1:0]        pixels_per_plane_i,
  input  logic                         pop_i,
  output logic                         head_pop_o,
  output logic                         out_valid_o,
  output logic [1:0]                   plane_index_o,
  output logic [PIXEL_FIELD_W-1:0]     first_pixel_o,
  output logic [7:0]                   run_count_o,
  output logic [7:0]                   sample_value_o,
  output logic                         image_done_o
);

  localparam int unsigned PixW  = PIXEL_INDEX_WIDTH;
  localparam int unsigned PixW1 = PIXEL_INDEX_WIDTH + 1;

  logic              valid_q;
  logic              load;
  logic [PixW1-1:0]  run_end;
  logic [PixW1-1:0]  size_ext;
  logic              done;

  assign size_ext = PixW1'(PixW'(pixels_per_plane_i));
  assign run_end  = PixW1'(head_pos_i) + PixW1'(head_run_i.count);
  assign done     = head_run_i.last_plane && (run_end >= size_ext);

  // Refill the output register when it is empty or its beat leaves
  assign load       = head_valid_i && (!valid_q || pop_i);
  assign head_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      plane_index_o  <= head_run_i.plane;
      first_pixel_o  <= PIXEL_FIELD_W'(head_pos_i);
      run_count_o    <= head_run_i.count;
      sample_value_o <= head_run_i.value;
      image_done_o   <= done;
    end
  end

  assign out_valid_o = valid_q;

endmodule

// ===== rtl/planar_packbits_image_decoder_core.sv =====
// Planar PackBits image decoder.
// Input queue side: one stream byte per beat on data_byte_i, with
// start_of_image_i set on the first byte of a new image; a beat is taken
// when push is high and full is low. Each accepted byte yields at most one
// run (plane, first pixel, count, value, image_done).
// Result queue side: the oldest run is on the result ports while empty is
// low and leaves when pop is high.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i selecting
// pixels_per_plane (0), planes_coded (1) or compressed_mode (2); write only
// while no runs are outstanding.
// Throughput: one byte per cycle while full is low; the parser state is registered.
// Path: the front writes the run into the run queue, then the back loads it
// into the output register that drives the result ports; a full output
// register holds the run in the queue until its beat leaves.
// Stall: a four-entry run queue sits behind the output register; full
// rises once it holds four runs, so a stalled receiver backs up the input
// after five undelivered runs.
// Reset: parser at header, plane and pixel zero, queue empty; registers
// come up as pixels_per_plane 1, planes_coded 3, compressed_mode 1.
module planar_packbits_image_decoder_core import ppbd_pkg::*; #(
  parameter int unsigned PIXEL_INDEX_WIDTH = 24
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push,
  output logic                     full,
  input  logic [7:0]               data_byte_i,
  input  logic                     start_of_image_i,
  output logic                     empty,
  input  logic                     pop,
  output logic [1:0]               plane_index_o,
  output logic [PIXEL_FIELD_W-1:0] first_pixel_o,
  output logic [7:0]               run_count_o,
  output logic [7:0]               sample_value_o,
  output logic                     image_done_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [1:0]               cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned PixW   = PIXEL_INDEX_WIDTH;
  localparam int unsigned EntryW = PixW + $bits(ppbd_run_t);

  logic [CFG_DATA_W-1:0] pixels_per_plane_q;
  logic [2:0]            planes_coded_q;
  logic                  compressed_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixels_per_plane_q <= CFG_DATA_W'(1);
      planes_coded_q     <= 3'd3;
      compressed_mode_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PIXELS_PER_PLANE: pixels_per_plane_q <= cfg_data_i;
        CFG_PLANES_CODED:     planes_coded_q     <= cfg_data_i[2:0];
        CFG_COMPRESSED_MODE:  compressed_mode_q  <= cfg_data_i[0];
        default:              ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  logic            accept;
  logic            q_full, q_empty, q_push, q_pop;
  logic [PixW-1:0] front_pos;
  ppbd_run_t       front_run;
  logic [EntryW-1:0] q_din, q_dout;
  logic [PixW-1:0] head_pos;
  ppbd_run_t       head_run;
  logic            out_valid;

  assign accept = push && !q_full;
  assign full   = q_full;

  ppbd_front #(.PIXEL_INDEX_WIDTH(PIXEL_INDEX_WIDTH)) u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .data_byte_i        (data_byte_i),
    .start_of_image_i   (start_of_image_i),
    .pixels_per_plane_i (pixels_per_plane_q),
    .planes_coded_i     (planes_coded_q),
    .compressed_mode_i  (compressed_mode_q),
    .push_o             (q_push),
    .pos_o              (front_pos),
    .run_o              (front_run)
  );

  assign q_din = {front_pos, front_run};

  ppbd_fifo #(.Width(EntryW), .Depth(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_din),
    .pop_i   (q_pop),
    .data_o  (q_dout),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign head_pos = q_dout[EntryW-1 -: PixW];
  assign head_run = q_dout[$bits(ppbd_run_t)-1:0];

  ppbd_back #(.PIXEL_INDEX_WIDTH(PIXEL_INDEX_WIDTH)) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .head_valid_i       (!q_empty),
    .head_pos_i         (head_pos),
    .head_run_i         (head_run),
    .pixels_per_plane_i (pixels_per_plane_q),
    .pop_i              (pop && out_valid),
    .head_pop_o         (q_pop),
    .out_valid_o        (out_valid),
    .plane_index_o      (plane_index_o),
    .first_pixel_o      (first_pixel_o),
    .run_count_o        (run_count_o),
    .sample_value_o     (sample_value_o),
    .image_done_o       (image_done_o)
  );

  assign empty = !out_valid;

endmodule
